>>> rtl/cfbs_pkg.sv
// cfbs_pkg: sizes, packet constants, request and register codes for the column
// frame buffer packet streamer. No dependencies.
`timescale 1ns / 1ps

package cfbs_pkg;

   localparam int BUF_COLS        = 256;
   localparam int BUF_ROWS        = 128;
   localparam int COLS_PER_PACKET = 128;

   localparam int COL_BYTES   = (BUF_ROWS + 7) / 8;
   localparam int ROW_BITS    = COL_BYTES * 8;
   localparam int NUM_PACKETS = (BUF_COLS + COLS_PER_PACKET - 1) / COLS_PER_PACKET;
   localparam int DATA_LEN    = COLS_PER_PACKET * COL_BYTES;

   localparam int COL_W  = (BUF_COLS > 1) ? $clog2(BUF_COLS) : 1;
   localparam int CB_W   = $clog2(NUM_PACKETS * COLS_PER_PACKET + 1);
   localparam int BSEL_W = (COL_BYTES > 1) ? $clog2(COL_BYTES) : 1;
   localparam int BIT_W  = $clog2(ROW_BITS);
   localparam int BX_W   = $clog2(DATA_LEN + 11);

   localparam logic [15:0] PKT_LEN16  = 16'((DATA_LEN + 6) % 65536);
   localparam logic [15:0] DATA_LEN16 = 16'(DATA_LEN % 65536);

   localparam logic [7:0] SOF_BYTE   = 8'hAA;
   localparam logic [7:0] CMD_COLUMN = 8'h13;
   localparam logic [7:0] CMD_UPDATE = 8'h15;
   localparam logic [7:0] CMD_SWITCH = 8'h11;
   localparam logic [7:0] CMD_BRIGHT = 8'h12;
   localparam logic [7:0] BRIGHT_LEN = 8'h01;
   localparam logic [7:0] INV_MASK   = 8'hFF;

   localparam logic [2:0] REQ_TICK    = 3'd0;
   localparam logic [2:0] REQ_PIXEL   = 3'd1;
   localparam logic [2:0] REQ_CLEAR   = 3'd2;
   localparam logic [2:0] REQ_REFRESH = 3'd3;
   localparam logic [2:0] REQ_BRIGHT  = 3'd4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_DISP_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPSIDE_DOWN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_OUT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_WAIT    = 3'd4;

   localparam logic [8:0]  DISP_WIDTH_RST  = 9'd256;
   localparam logic [7:0]  DISP_HEIGHT_RST = 8'd128;
   localparam logic [13:0] ACK_WAIT_RST    = 14'd10000;

endpackage

>>> rtl/column_framebuffer_packet_streamer.sv
// A request beat is accepted only while idle, and its column store read is registered; the
// modify, write back and result beat register follow when the output is not stalled (rsp_valid
// low or rsp_ready high). No new request is taken before that, as the store has one read port.
// Reset: synchronous; per-column valid flags are cleared at once, so the store reads
// as zero right after reset and after a clear request, with no clearing pass.
// Depends on cfbs_pkg and cfbs_ram.
`timescale 1ns / 1ps

module column_framebuffer_packet_streamer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_type,
   input  logic [7:0]                      req_px_x,
   input  logic [6:0]                      req_px_y,
   input  logic                            req_px_white,
   input  logic [7:0]                      req_bright_level,
   input  logic                            req_rx_valid,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_tx_valid,
   output logic [7:0]                      rsp_tx_byte,
   output logic                            rsp_packet_last,
   output logic                            rsp_busy_res,
   output logic                            rsp_ack_timed_out,
   output logic                            rsp_seq_done,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cfbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cfbs_pkg::CSR_DATA_W-1:0] csr_data
);
   import cfbs_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_COL  = 3'd1;
   localparam logic [2:0] PH_UPD  = 3'd2;
   localparam logic [2:0] PH_SW   = 3'd3;
   localparam logic [2:0] PH_BRI  = 3'd4;

   // configuration
   logic [8:0]  disp_width_ff, disp_width_in;
   logic [7:0]  disp_height_ff, disp_height_in;
   logic        upside_down_ff, upside_down_in;
   logic        invert_out_ff, invert_out_in;
   logic [13:0] ack_wait_ff, ack_wait_in;

   // control
   logic                state_ff, state_in;
   logic [2:0]          phase_ff, phase_in;
   logic                in_wait_ff, in_wait_in;
   logic [BX_W-1:0]     byte_idx_ff, byte_idx_in;
   logic [2:0]          ack_cnt_ff, ack_cnt_in;
   logic [13:0]         wait_left_ff, wait_left_in;
   logic [7:0]          bright_ff, bright_in;
   logic [CB_W-1:0]     rd_col_ff, rd_col_in;
   logic [BSEL_W-1:0]   rd_byte_ff, rd_byte_in;
   logic [BUF_COLS-1:0] col_valid_ff, col_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // latched request beat
   logic [2:0]       it_type_ff;
   logic             it_white_ff;
   logic [7:0]       it_bright_ff;
   logic             it_rx_ff;
   logic             pix_ok_ff;
   logic [COL_W-1:0] pix_col_ff;
   logic [BIT_W-1:0] pix_bit_ff;
   logic             rd_ok_ff;

   // result beat
   logic       tx_valid_ff, tx_valid_in;
   logic [7:0] tx_byte_ff, tx_byte_in;
   logic       plast_ff, plast_in;
   logic       busy_ff, busy_in;
   logic       tout_ff, tout_in;
   logic       done_ff, done_in;

   // accept-side decode
   logic             req_fire;
   logic             pix_in_rng;
   logic [8:0]       pix_xm;
   logic [7:0]       pix_ym;
   logic             pix_ok;
   logic [COL_W-1:0] rd_addr;
   logic             rd_ok;

   // store
   logic                ram_we;
   logic [ROW_BITS-1:0] ram_q;
   logic [ROW_BITS-1:0] row_q;
   logic [ROW_BITS-1:0] row_new;

   // exec-side helpers
   logic       exec_fire;
   logic       pkt_last;
   logic [2:0] ack_new;
   logic [13:0] wait_new;
   logic       wait_end;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign pix_in_rng = ({1'b0, req_px_x} < disp_width_ff) && ({1'b0, req_px_y} < disp_height_ff);
   assign pix_xm = upside_down_ff ? (disp_width_ff - 9'd1 - {1'b0, req_px_x}) : {1'b0, req_px_x};
   assign pix_ym = upside_down_ff ? (disp_height_ff - 8'd1 - {1'b0, req_px_y})
                                  : {1'b0, req_px_y};
   assign pix_ok = pix_in_rng && (32'(pix_xm) < BUF_COLS) && (32'(pix_ym) < BUF_ROWS);
   assign rd_addr = (req_type == REQ_PIXEL) ? COL_W'(pix_xm) : COL_W'(rd_col_ff);
   assign rd_ok = ((req_type == REQ_PIXEL) ? pix_ok : (32'(rd_col_ff) < BUF_COLS))
                  && col_valid_ff[rd_addr];

   cfbs_ram #(
      .WIDTH(ROW_BITS),
      .DEPTH(BUF_COLS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(pix_col_ff),
      .wr_data(row_new),
      .rd_en  (req_fire),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   assign row_q = rd_ok_ff ? ram_q : '0;

   always_comb begin
      row_new = row_q;
      row_new[pix_bit_ff] = it_white_ff;
   end

   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // configuration writes
   always_comb begin
      disp_width_in  = disp_width_ff;
      disp_height_in = disp_height_ff;
      upside_down_in = upside_down_ff;
      invert_out_in  = invert_out_ff;
      ack_wait_in    = ack_wait_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DISP_WIDTH:  disp_width_in  = csr_data[8:0];
            CSR_DISP_HEIGHT: disp_height_in = csr_data[7:0];
            CSR_UPSIDE_DOWN: upside_down_in = csr_data[0];
            CSR_INVERT_OUT:  invert_out_in  = csr_data[0];
            CSR_ACK_WAIT:    ack_wait_in    = csr_data[13:0];
            default: ;
         endcase
      end
   end

   // read-modify-write and sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      in_wait_in   = in_wait_ff;
      byte_idx_in  = byte_idx_ff;
      ack_cnt_in   = ack_cnt_ff;
      wait_left_in = wait_left_ff;
      bright_in    = bright_ff;
      rd_col_in    = rd_col_ff;
      rd_byte_in   = rd_byte_ff;
      col_valid_in = col_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      tx_valid_in  = tx_valid_ff;
      tx_byte_in   = tx_byte_ff;
      plast_in     = plast_ff;
      busy_in      = busy_ff;
      tout_in      = tout_ff;
      done_in      = done_ff;
      pkt_last     = 1'b0;
      ack_new      = ack_cnt_ff + {2'b00, it_rx_ff};
      wait_new     = wait_left_ff - 14'd1;
      wait_end     = 1'b0;

      if (req_fire) begin
         state_in = ST_EXEC;
      end

      if (exec_fire) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         tx_valid_in  = 1'b0;
         tx_byte_in   = 8'h00;
         plast_in     = 1'b0;
         tout_in      = 1'b0;
         done_in      = 1'b0;

         if (phase_ff == PH_IDLE) begin
            case (it_type_ff)
               REQ_PIXEL: begin
                  if (pix_ok_ff) begin
                     ram_we = 1'b1;
                     col_valid_in[pix_col_ff] = 1'b1;
                  end
               end
               REQ_CLEAR: begin
                  col_valid_in = '0;
               end
               REQ_REFRESH, REQ_BRIGHT: begin
                  phase_in = (it_type_ff == REQ_REFRESH) ? PH_COL : PH_BRI;
                  if (it_type_ff == REQ_BRIGHT) begin
                     bright_in = it_bright_ff;
                  end
                  in_wait_in   = 1'b0;
                  byte_idx_in  = '0;
                  ack_cnt_in   = 3'd0;
                  wait_left_in = 14'd0;
                  rd_col_in    = '0;
                  rd_byte_in   = '0;
               end
               default: ;
            endcase
         end else if (it_type_ff == REQ_TICK) begin
            if (!in_wait_ff) begin
               tx_valid_in = 1'b1;
               byte_idx_in = byte_idx_ff + 1'b1;
               case (phase_ff)
                  PH_COL: begin
                     pkt_last = (byte_idx_ff == BX_W'(DATA_LEN + 9));
                     if (byte_idx_ff < BX_W'(10)) begin
                        case (byte_idx_ff[3:0])
                           4'd0:    tx_byte_in = SOF_BYTE;
                           4'd1:    tx_byte_in = CMD_COLUMN;
                           4'd2:    tx_byte_in = PKT_LEN16[15:8];
                           4'd3:    tx_byte_in = PKT_LEN16[7:0];
                           4'd4:    tx_byte_in = 8'(16'(rd_col_ff) >> 8);
                           4'd5:    tx_byte_in = 8'(16'(rd_col_ff));
                           4'd8:    tx_byte_in = DATA_LEN16[15:8];
                           4'd9:    tx_byte_in = DATA_LEN16[7:0];
                           default: tx_byte_in = 8'h00;
                        endcase
                     end else begin
                        tx_byte_in = row_q[{rd_byte_ff, 3'b000} +: 8]
                                     ^ (invert_out_ff ? INV_MASK : 8'h00);
                        if (rd_byte_ff == BSEL_W'(COL_BYTES - 1)) begin
                           rd_byte_in = '0;
                           rd_col_in  = rd_col_ff + 1'b1;
                        end else begin
                           rd_byte_in = rd_byte_ff + 1'b1;
                        end
                     end
                  end
                  PH_BRI: begin
                     pkt_last = (byte_idx_ff >= BX_W'(4));
                     case (byte_idx_ff)
                        BX_W'(0): tx_byte_in = SOF_BYTE;
                        BX_W'(1): tx_byte_in = CMD_BRIGHT;
                        BX_W'(2): tx_byte_in = 8'h00;
                        BX_W'(3): tx_byte_in = BRIGHT_LEN;
                        default:  tx_byte_in = bright_ff;
                     endcase
                  end
                  default: begin
                     pkt_last = (byte_idx_ff >= BX_W'(3));
                     case (byte_idx_ff)
                        BX_W'(0): tx_byte_in = SOF_BYTE;
                        BX_W'(1): tx_byte_in = (phase_ff == PH_UPD) ? CMD_UPDATE : CMD_SWITCH;
                        default:  tx_byte_in = 8'h00;
                     endcase
                  end
               endcase
               if (pkt_last) begin
                  plast_in     = 1'b1;
                  in_wait_in   = 1'b1;
                  ack_cnt_in   = 3'd0;
                  wait_left_in = ack_wait_ff;
               end
            end else begin
               if (wait_left_ff == 14'd0) begin
                  wait_end = 1'b1;
                  tout_in  = 1'b1;
               end else begin
                  ack_cnt_in   = ack_new;
                  wait_left_in = wait_new;
                  tout_in      = (wait_new == 14'd0);
                  wait_end     = ack_new[2] || (wait_new == 14'd0);
               end
               if (wait_end) begin
                  in_wait_in  = 1'b0;
                  byte_idx_in = '0;
                  ack_cnt_in  = 3'd0;
                  case (phase_ff)
                     PH_COL: begin
                        if (32'(rd_col_ff) >= BUF_COLS) begin
                           rd_col_in = '0;
                           phase_in  = PH_UPD;
                        end
                     end
                     PH_UPD: phase_in = PH_SW;
                     default: begin
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                     end
                  endcase
               end
            end
         end
         busy_in = (phase_in != PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_width_ff  <= DISP_WIDTH_RST;
         disp_height_ff <= DISP_HEIGHT_RST;
         upside_down_ff <= 1'b0;
         invert_out_ff  <= 1'b0;
         ack_wait_ff    <= ACK_WAIT_RST;
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_IDLE;
         in_wait_ff     <= 1'b0;
         byte_idx_ff    <= '0;
         ack_cnt_ff     <= 3'd0;
         wait_left_ff   <= 14'd0;
         bright_ff      <= 8'h00;
         rd_col_ff      <= '0;
         rd_byte_ff     <= '0;
         col_valid_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         disp_width_ff  <= disp_width_in;
         disp_height_ff <= disp_height_in;
         upside_down_ff <= upside_down_in;
         invert_out_ff  <= invert_out_in;
         ack_wait_ff    <= ack_wait_in;
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         in_wait_ff     <= in_wait_in;
         byte_idx_ff    <= byte_idx_in;
         ack_cnt_ff     <= ack_cnt_in;
         wait_left_ff   <= wait_left_in;
         bright_ff      <= bright_in;
         rd_col_ff      <= rd_col_in;
         rd_byte_ff     <= rd_byte_in;
         col_valid_ff   <= col_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         it_type_ff   <= req_type;
         it_white_ff  <= req_px_white;
         it_bright_ff <= req_bright_level;
         it_rx_ff     <= req_rx_valid;
         pix_ok_ff    <= pix_ok;
         pix_col_ff   <= COL_W'(pix_xm);
         pix_bit_ff   <= BIT_W'({pix_ym[7:3], ~pix_ym[2:0]});
         rd_ok_ff     <= rd_ok;
      end
      tx_valid_ff <= tx_valid_in;
      tx_byte_ff  <= tx_byte_in;
      plast_ff    <= plast_in;
      busy_ff     <= busy_in;
      tout_ff     <= tout_in;
      done_ff     <= done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_valid      = tx_valid_ff;
   assign rsp_tx_byte       = tx_byte_ff;
   assign rsp_packet_last   = plast_ff;
   assign rsp_busy_res      = busy_ff;
   assign rsp_ack_timed_out = tout_ff;
   assign rsp_seq_done      = done_ff;

endmodule

>>> rtl/cfbs_ram.sv
// cfbs_ram: generic simple dual port ram, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module cfbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/tb_column_framebuffer_packet_streamer.sv
// tb_column_framebuffer_packet_streamer: drives pixel, clear, refresh and brightness requests
// and checks every link beat against a behavioral model of the streamer kept in the bench.
// Depends on cfbs_pkg and column_framebuffer_packet_streamer.
`timescale 1ns / 1ps

module tb_column_framebuffer_packet_streamer;
   import cfbs_pkg::*;

   localparam int STORE_BYTES = BUF_COLS * COL_BYTES;
   localparam int NUM_PHASES  = 7;
   localparam int PHASE_ITEMS = 200;
   localparam int CYCLE_LIMIT = 2000000;

   typedef enum logic [2:0] {PH_IDLE, PH_COLUMN, PH_UPDATE, PH_SWITCH, PH_BRIGHT}
      stream_phase_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] px_x;
      logic [6:0] px_y;
      logic       white;
      logic [7:0] lvl;
      logic       rx;
   } req_item_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       last;
      logic       busy;
      logic       timed_out;
      logic       done;
   } link_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_type = REQ_TICK;
   logic [7:0]            req_px_x = '0;
   logic [6:0]            req_px_y = '0;
   logic                  req_px_white = 1'b0;
   logic [7:0]            req_bright_level = '0;
   logic                  req_rx_valid = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_tx_valid;
   logic [7:0]            rsp_tx_byte;
   logic                  rsp_packet_last;
   logic                  rsp_busy_res;
   logic                  rsp_ack_timed_out;
   logic                  rsp_seq_done;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_DISP_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // register copies
   logic [8:0]  cfg_width    = DISP_WIDTH_RST;
   logic [7:0]  cfg_height   = DISP_HEIGHT_RST;
   logic        cfg_upside   = 1'b0;
   logic        cfg_invert   = 1'b0;
   logic [13:0] cfg_ack_wait = ACK_WAIT_RST;

   // streamer state copy
   logic [7:0]       fb_copy [STORE_BYTES] = '{default: 8'h00};
   stream_phase_type strm_phase  = PH_IDLE;
   int unsigned      pkt_idx     = 0;
   logic [11:0]      byte_idx    = '0;
   logic [2:0]       ack_cnt     = '0;
   logic [13:0]      wait_left   = '0;
   logic [7:0]       bright_copy = '0;
   logic             in_wait     = 1'b0;

   req_item_type  req_backlog [$];
   link_beat_type link_beats_due [$];
   req_item_type  req_on_bus;
   link_beat_type got_beat;
   link_beat_type want_beat;
   int unsigned reqs_posted   = 0;
   int unsigned reqs_accepted = 0;
   int unsigned beats_seen    = 0;
   int unsigned mismatches    = 0;
   int unsigned cycle_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   logic [2:0] ignored_kinds [4] = '{REQ_PIXEL, REQ_CLEAR, REQ_REFRESH, REQ_BRIGHT};

   int unsigned phase_width  [NUM_PHASES] = '{256, 1, 256, 200, 97, 256, 1};
   int unsigned phase_height [NUM_PHASES] = '{128, 1, 128, 100, 64, 1, 128};
   int unsigned phase_upside [NUM_PHASES] = '{0, 1, 1, 0, 1, 1, 0};
   int unsigned phase_invert [NUM_PHASES] = '{0, 1, 0, 1, 1, 1, 0};
   int unsigned phase_wait   [NUM_PHASES] = '{10000, 1, 16383, 37, 5, 3, 12};
   int unsigned phase_idle   [NUM_PHASES] = '{0, 66, 0, 37, 0, 66, 0};
   int unsigned phase_stall  [NUM_PHASES] = '{0, 0, 66, 37, 0, 0, 66};

   column_framebuffer_packet_streamer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_px_x          (req_px_x),
      .req_px_y          (req_px_y),
      .req_px_white      (req_px_white),
      .req_bright_level  (req_bright_level),
      .req_rx_valid      (req_rx_valid),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_packet_last   (rsp_packet_last),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_ack_timed_out (rsp_ack_timed_out),
      .rsp_seq_done      (rsp_seq_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   function automatic link_beat_type advance_streamer(input req_item_type it);
      link_beat_type r;
      int unsigned   x, y, a, bi;
      logic [7:0]    m;
      logic [15:0]   first_col;
      logic          fin;
      r = '0;
      fin = 1'b0;
      if (strm_phase == PH_IDLE) begin
         if (it.kind == REQ_PIXEL) begin
            x = it.px_x;
            y = it.px_y;
            if (x < cfg_width && y < cfg_height) begin
               if (cfg_upside) begin
                  x = cfg_width - 1 - x;
                  y = cfg_height - 1 - y;
               end
               if (x < BUF_COLS && y < BUF_ROWS) begin
                  a = x * COL_BYTES + y / 8;
                  m = 8'h80 >> (y % 8);
                  fb_copy[a] = it.white ? (fb_copy[a] | m) : (fb_copy[a] & ~m);
               end
            end
         end else if (it.kind == REQ_CLEAR) begin
            foreach (fb_copy[i]) fb_copy[i] = 8'h00;
         end else if (it.kind == REQ_REFRESH || it.kind == REQ_BRIGHT) begin
            strm_phase = (it.kind == REQ_REFRESH) ? PH_COLUMN : PH_BRIGHT;
            if (it.kind == REQ_BRIGHT) bright_copy = it.lvl;
            pkt_idx = 0;
            byte_idx = '0;
            ack_cnt = '0;
            wait_left = '0;
            in_wait = 1'b0;
         end
      end else if (it.kind == REQ_TICK) begin
         if (!in_wait) begin
            r.tx_valid = 1'b1;
            bi = byte_idx;
            case (strm_phase)
               PH_COLUMN: begin
                  first_col = 16'(pkt_idx * COLS_PER_PACKET);
                  r.last = (bi + 1 >= 10 + DATA_LEN);
                  case (bi)
                     0: r.tx_byte = SOF_BYTE;
                     1: r.tx_byte = CMD_COLUMN;
                     2: r.tx_byte = PKT_LEN16[15:8];
                     3: r.tx_byte = PKT_LEN16[7:0];
                     4: r.tx_byte = first_col[15:8];
                     5: r.tx_byte = first_col[7:0];
                     6, 7: r.tx_byte = 8'h00;
                     8: r.tx_byte = DATA_LEN16[15:8];
                     9: r.tx_byte = DATA_LEN16[7:0];
                     default: begin
                        a = pkt_idx * DATA_LEN + bi - 10;
                        r.tx_byte = ((a < STORE_BYTES) ? fb_copy[a] : 8'h00)
                                    ^ (cfg_invert ? INV_MASK : 8'h00);
                     end
                  endcase
               end
               PH_BRIGHT: begin
                  r.last = (bi >= 4);
                  case (bi)
                     0: r.tx_byte = SOF_BYTE;
                     1: r.tx_byte = CMD_BRIGHT;
                     2: r.tx_byte = 8'h00;
                     3: r.tx_byte = BRIGHT_LEN;
                     default: r.tx_byte = bright_copy;
                  endcase
               end
               default: begin
                  r.last = (bi >= 3);
                  case (bi)
                     0: r.tx_byte = SOF_BYTE;
                     1: r.tx_byte = (strm_phase == PH_UPDATE) ? CMD_UPDATE : CMD_SWITCH;
                     default: r.tx_byte = 8'h00;
                  endcase
               end
            endcase
            byte_idx = byte_idx + 1'b1;
            if (r.last) begin
               in_wait = 1'b1;
               ack_cnt = '0;
               wait_left = cfg_ack_wait;
            end
         end else begin
            if (wait_left == 0) begin
               fin = 1'b1;
               r.timed_out = 1'b1;
            end else begin
               ack_cnt = ack_cnt + 3'(it.rx);
               wait_left = wait_left - 1'b1;
               r.timed_out = (wait_left == 0);
               fin = (ack_cnt >= 4) || r.timed_out;
            end
            if (fin) begin
               in_wait = 1'b0;
               byte_idx = '0;
               ack_cnt = '0;
               if (strm_phase == PH_COLUMN) begin
                  pkt_idx++;
                  if (pkt_idx >= NUM_PACKETS) begin
                     pkt_idx = 0;
                     strm_phase = PH_UPDATE;
                  end
               end else if (strm_phase == PH_UPDATE) begin
                  strm_phase = PH_SWITCH;
               end else begin
                  strm_phase = PH_IDLE;
                  r.done = 1'b1;
               end
            end
         end
      end
      r.busy = (strm_phase != PH_IDLE);
      return r;
   endfunction

   function automatic req_item_type any_fields(input logic [2:0] kind);
      req_item_type it;
      it.kind = kind;
      it.px_x = 8'($urandom);
      it.px_y = 7'($urandom);
      it.white = 1'($urandom);
      it.lvl = 8'($urandom);
      it.rx = 1'($urandom);
      return it;
   endfunction

   function automatic void post(input req_item_type it);
      req_backlog.push_back(it);
      reqs_posted++;
   endfunction

   function automatic void post_pixel(input int unsigned x, input int unsigned y,
                                      input logic white);
      req_item_type it;
      it = any_fields(REQ_PIXEL);
      it.px_x = 8'(x);
      it.px_y = 7'(y);
      it.white = white;
      post(it);
   endfunction

   // requests while busy are dropped by the block
   function automatic void sprinkle(input int unsigned pct);
      if ($urandom_range(99) < pct) post(any_fields(ignored_kinds[$urandom_range(3)]));
   endfunction

   // full refresh or brightness sequence, ack pattern planned against the wait setting
   function automatic void queue_sequence(input logic refresh, input logic [7:0] lvl,
                                          input int unsigned noise_pct);
      req_item_type it;
      int unsigned  npk, len, acks, k, w, p, i;
      logic         quiet;
      it = any_fields(refresh ? REQ_REFRESH : REQ_BRIGHT);
      it.lvl = lvl;
      post(it);
      npk = refresh ? NUM_PACKETS + 2 : 1;
      for (p = 0; p < npk; p++) begin
         len = !refresh ? 5 : ((p < NUM_PACKETS) ? 10 + DATA_LEN : 4);
         for (i = 0; i < len; i++) begin
            sprinkle(noise_pct);
            post(any_fields(REQ_TICK));
         end
         w = cfg_ack_wait;
         acks = 0;
         k = 0;
         quiet = (w <= 60) && ($urandom_range(1) == 1);
         do begin
            sprinkle(noise_pct);
            it = any_fields(REQ_TICK);
            if (quiet) it.rx = 1'b0;
            post(it);
            acks += it.rx;
            k++;
         end while (acks < 4 && k < w);
      end
   endfunction

   task automatic drain;
      do @(negedge clock);
      while (reqs_accepted != reqs_posted || link_beats_due.size() != 0);
      @(posedge clock);
   endtask

   task automatic settle;
      req_item_type it;
      drain();
      while (strm_phase != PH_IDLE) begin
         it = any_fields(REQ_TICK);
         it.rx = 1'b1;
         post(it);
         drain();
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'(val);
      csr_index <= idx;
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (csr_ready !== 1'b1);
      case (idx)
         CSR_DISP_WIDTH:  cfg_width = v[8:0];
         CSR_DISP_HEIGHT: cfg_height = v[7:0];
         CSR_UPSIDE_DOWN: cfg_upside = v[0];
         CSR_INVERT_OUT:  cfg_invert = v[0];
         CSR_ACK_WAIT:    cfg_ack_wait = v[13:0];
         default: ;
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            link_beats_due.push_back(advance_streamer(req_on_bus));
            reqs_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_on_bus = req_backlog.pop_front();
               req_valid <= 1'b1;
               req_type <= req_on_bus.kind;
               req_px_x <= req_on_bus.px_x;
               req_px_y <= req_on_bus.px_y;
               req_px_white <= req_on_bus.white;
               req_bright_level <= req_on_bus.lvl;
               req_rx_valid <= req_on_bus.rx;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // link beat monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_beat = '{rsp_tx_valid, rsp_tx_byte, rsp_packet_last, rsp_busy_res,
                         rsp_ack_timed_out, rsp_seq_done};
            if (link_beats_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d: none expected, got tx %b %h last %b busy %b tmo %b done %b",
                           beats_seen, got_beat.tx_valid, got_beat.tx_byte, got_beat.last,
                           got_beat.busy, got_beat.timed_out, got_beat.done);
            end else begin
               want_beat = link_beats_due.pop_front();
               if (got_beat.tx_valid !== want_beat.tx_valid
                   || got_beat.tx_byte !== want_beat.tx_byte
                   || got_beat.last !== want_beat.last
                   || got_beat.busy !== want_beat.busy
                   || got_beat.timed_out !== want_beat.timed_out
                   || got_beat.done !== want_beat.done) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("beat %0d: expected tx %b %h last %b busy %b tmo %b done %b,",
                            beats_seen, want_beat.tx_valid, want_beat.tx_byte,
                            want_beat.last, want_beat.busy, want_beat.timed_out,
                            want_beat.done);
                     $display(" got tx %b %h last %b busy %b tmo %b done %b",
                              got_beat.tx_valid, got_beat.tx_byte, got_beat.last,
                              got_beat.busy, got_beat.timed_out, got_beat.done);
                  end
               end
            end
            beats_seen++;
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_column_framebuffer_packet_streamer: errors");
         $finish;
      end
   end

   initial begin
      req_item_type it;
      int           n, p, pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // corners, black after white, idle tick, both brightness extremes, readback, clear
      post_pixel(0, 0, 1'b1);
      post_pixel(255, 127, 1'b1);
      post_pixel(255, 0, 1'b1);
      post_pixel(0, 127, 1'b1);
      post_pixel(9, 10, 1'b1);
      post_pixel(9, 10, 1'b0);
      post_pixel(9, 11, 1'b1);
      it = any_fields(REQ_TICK);
      it.rx = 1'b1;
      post(it);
      queue_sequence(1'b0, 8'hFF, 50);
      queue_sequence(1'b0, 8'h00, 0);
      queue_sequence(1'b1, 8'($urandom), 0);
      post(any_fields(REQ_CLEAR));
      post_pixel(3, 3, 1'b1);
      settle();

      for (p = 0; p < NUM_PHASES; p++) begin
         write_reg(CSR_DISP_WIDTH, phase_width[p]);
         write_reg(CSR_DISP_HEIGHT, phase_height[p]);
         write_reg(CSR_UPSIDE_DOWN, phase_upside[p]);
         write_reg(CSR_INVERT_OUT, phase_invert[p]);
         write_reg(CSR_ACK_WAIT, phase_wait[p]);
         csr_valid <= 1'b0;
         send_idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) drain();
            pick = $urandom_range(99);
            if (pick < 68) begin
               it = any_fields(REQ_PIXEL);
               if ($urandom_range(99) < 80) begin
                  it.px_x = 8'($urandom_range(cfg_width - 1));
                  it.px_y = 7'($urandom_range(cfg_height - 1));
               end
               it.white = ($urandom_range(99) < 70);
               post(it);
            end else if (pick < 70) begin
               post(any_fields(REQ_CLEAR));
            end else if (pick < 88) begin
               post(any_fields(REQ_TICK));
            end else begin
               queue_sequence(1'b0, 8'($urandom), 5);
            end
         end
         queue_sequence(1'b1, 8'($urandom), 1);
         settle();
      end

      send_idle_pct = 0;
      stall_pct = 0;
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_column_framebuffer_packet_streamer: clean");
      end else begin
         $display("tb_column_framebuffer_packet_streamer: errors");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/cfbs_pkg.sv
rtl/cfbs_ram.sv
rtl/column_framebuffer_packet_streamer.sv
tb/tb_column_framebuffer_packet_streamer.sv
